FILE: hw/rtl/pgsg_pkg.sv
`default_nettype none

package pgsg_pkg;

    // Sample width default; the top level parameter takes it from here
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed register widths
    localparam int THR_W      = 16;
    localparam int GAIN_W     = 17;
    localparam int WEIGHT_W   = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAIN       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_WEIGHT     = 2'd2;

    // Register reset values: threshold ~0.05, gain 2.0, weight ~0.2
    localparam logic [THR_W-1:0]    THR_RST    = 16'd1638;
    localparam logic [GAIN_W-1:0]   GAIN_RST   = 17'd65536;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 9'd51;

    // Smoothing arithmetic: weights in Q1.8, rounded half up
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;
    localparam int MIX_W     = 26;
    localparam int MIX_SHIFT = 8;
    localparam int MIX_ROUND = 128;

    // Playback product rounding and shift
    localparam int PLAY_SHIFT = 15;
    localparam int PLAY_ROUND = 16384;

    // Gain operand of the shared multiplier is 17 bits unsigned, one sign bit on top
    localparam int MUL_B_W = GAIN_W + 1;

    // Width of the other multiplier operand: a sample, a peak or a weight, signed
    function automatic int mul_a_w(input int sb);
        return (sb > WEIGHT_W) ? sb + 1 : WEIGHT_W + 1;
    endfunction

    // What the shared multiplier works on in a given cycle
    typedef enum logic [1:0] {
        MUL_GAIN,   // peak x max_gain
        MUL_KEEP,   // (1 - w) x smoothed gain
        MUL_NEW,    // w x new gain
        MUL_PLAY    // sample x smoothed gain
    } t_mul_op;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAIN,
        ST_CLAMP,
        ST_MIX,
        ST_SUM,
        ST_PMUL,
        ST_PSAT
    } t_state;

endpackage

`default_nettype wire

FILE: hw/rtl/pgsg_if.sv
`default_nettype none

// Input request channel: one audio sample with its kind and last mark
interface pgsg_in_if #(
    parameter int SAMPLE_BITS = pgsg_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          last;

    modport source (output valid, func, sample_in, last, input ready);
    modport sink   (input valid, func, sample_in, last, output ready);
endinterface

// Output request channel: one scaled playback sample
interface pgsg_out_if #(
    parameter int SAMPLE_BITS = pgsg_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          muted;
    logic                          last_out;

    modport source (output valid, sample_out, muted, last_out, input ready);
    modport sink   (input valid, sample_out, muted, last_out, output ready);
endinterface

// Configuration write channel
interface pgsg_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pgsg_pkg::CFG_IDX_W-1:0]    index;
    logic [pgsg_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/peak_gated_smoothed_gain_top.sv
`default_nettype none

// Noise gate with peak-envelope gain.
// Channels: i_in takes one sample request at a time (func 0 microphone,
// func 1 playback); o_out gives one scaled sample per playback request;
// i_cfg writes gate_threshold (0), max_gain (1) and new_weight (2), is always
// ready and must only be used while the block is idle.
// Sequence: a microphone sample is taken in ST_IDLE and the block stays idle. The
// last microphone sample of a buffer then goes to ST_GAIN and back when the gate
// closes, or through ST_GAIN, ST_CLAMP, ST_MIX and ST_SUM when it opens (peak x
// gain, clamp, two smoothing products, sum), all on one shared multiplier.
// A playback sample goes through ST_PMUL and ST_PSAT to the output register and
// shows on o_out the cycle after that; the next request is taken in that same
// cycle. i_in.ready is low while a request is being worked on.
// Stall: the output register holds a result until o_out.ready; a playback
// request waits in its last step until the register is free, so nothing is
// dropped.
// Reset (synchronous, active low): registers to their defaults, peak and
// smoothed gain to zero, gate closed, output empty.
module peak_gated_smoothed_gain_top #(
    parameter int SAMPLE_BITS = pgsg_pkg::SAMPLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pgsg_in_if.sink     i_in,
    pgsg_out_if.source  o_out,
    pgsg_cfg_if.sink    i_cfg
);
    import pgsg_pkg::*;

    localparam int A_W  = mul_a_w(SAMPLE_BITS);
    localparam int P_W  = A_W + MUL_B_W;
    localparam int SF   = SAMPLE_BITS - 1;
    localparam int G_W  = P_W - SF;
    localparam int Q_W  = P_W + 1 - PLAY_SHIFT;
    localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

    localparam logic signed [Q_W-1:0] SAT_HI = Q_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [Q_W-1:0] SAT_LO = ~SAT_HI;
    localparam logic [SAMPLE_BITS-1:0] PEAK_MAX = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Sequencer
    t_state  r_state, n_state;
    t_mul_op mul_op;
    logic    in_ready;
    logic    gate_close;
    logic    load_out;
    logic    out_free;

    // Registers and state
    logic [THR_W-1:0]              r_thr;
    logic [GAIN_W-1:0]             r_max_gain;
    logic [WEIGHT_W-1:0]           r_weight;
    logic [SAMPLE_BITS-1:0]        r_peak;
    logic [GAIN_W-1:0]             r_sg;
    logic                          r_gate_open;
    logic [GAIN_W-1:0]             r_gain;
    logic [MIX_W-1:0]              r_acc;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_last;

    // Output register
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                          r_out_muted;
    logic                          r_out_last;

    // Datapath
    logic signed [P_W-1:0]     prod;
    logic [SAMPLE_BITS-1:0]    mag;
    logic [WEIGHT_W-1:0]       w_clamp;
    logic [WEIGHT_W-1:0]       keep_w;
    logic [G_W-1:0]            gain_full;
    logic [GAIN_W-1:0]         gain_clamped;
    logic [MIX_W:0]            mix_sum;
    logic signed [P_W:0]       play_rnd;
    logic signed [Q_W-1:0]     play_q;
    logic signed [SAMPLE_BITS-1:0] play_sat;
    logic                      in_take;
    logic                      below_thr;

    assign in_take  = i_in.valid && in_ready;
    assign out_free = !r_out_valid || o_out.ready;

    // Magnitude of the incoming sample; full-scale negative stays exact
    assign mag = i_in.sample_in[SAMPLE_BITS-1]
               ? (~i_in.sample_in + SAMPLE_BITS'(1))
               : i_in.sample_in;

    // Smoothing weights, new weight capped at one
    assign w_clamp = (r_weight > WEIGHT_ONE) ? WEIGHT_ONE : r_weight;
    assign keep_w  = WEIGHT_ONE - w_clamp;

    assign below_thr = CMP_W'(r_peak) < CMP_W'(r_thr);

    // Gain from peak, truncated then clamped to max_gain
    assign gain_full    = prod[P_W-1:SF];
    assign gain_clamped = (gain_full > G_W'(r_max_gain)) ? r_max_gain : gain_full[GAIN_W-1:0];

    // Smoothed gain sum, rounded half up
    assign mix_sum = {1'b0, r_acc} + {1'b0, prod[MIX_W-1:0]} + (MIX_W+1)'(MIX_ROUND);

    // Playback: round, floor shift, saturate
    assign play_rnd = $signed({prod[P_W-1], prod}) + $signed((P_W+1)'(PLAY_ROUND));
    assign play_q   = play_rnd[P_W:PLAY_SHIFT];
    always_comb begin
        if (play_q > SAT_HI) begin
            play_sat = SAT_HI[SAMPLE_BITS-1:0];
        end else if (play_q < SAT_LO) begin
            play_sat = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            play_sat = play_q[SAMPLE_BITS-1:0];
        end
    end

    // Shared multiplier
    pgsg_mul #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mul (
        .i_clk      (i_clk),
        .i_op       (mul_op),
        .i_peak     (r_peak),
        .i_sample   (r_sample),
        .i_max_gain (r_max_gain),
        .i_gain     (r_gain),
        .i_smoothed (r_sg),
        .i_keep_w   (keep_w),
        .i_new_w    (w_clamp),
        .o_prod     (prod)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and controls
    always_comb begin
        n_state    = r_state;
        in_ready   = 1'b0;
        mul_op     = MUL_PLAY;
        gate_close = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    if (i_in.func) begin
                        n_state = ST_PMUL;
                    end else if (i_in.last) begin
                        n_state = ST_GAIN;
                    end
                end
            end
            ST_GAIN: begin
                mul_op = MUL_GAIN;
                if (below_thr) begin
                    gate_close = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    n_state = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                mul_op  = MUL_KEEP;
                n_state = ST_MIX;
            end
            ST_MIX: begin
                mul_op  = MUL_NEW;
                n_state = ST_SUM;
            end
            ST_SUM: begin
                n_state = ST_IDLE;
            end
            ST_PMUL: begin
                mul_op  = MUL_PLAY;
                n_state = ST_PSAT;
            end
            ST_PSAT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Configuration registers
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= THR_RST;
            r_max_gain <= GAIN_RST;
            r_weight   <= WEIGHT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_GATE_THRESHOLD: r_thr      <= i_cfg.data[THR_W-1:0];
                CFG_MAX_GAIN:       r_max_gain <= i_cfg.data[GAIN_W-1:0];
                CFG_NEW_WEIGHT:     r_weight   <= i_cfg.data[WEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Peak, gate and smoothed gain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak      <= '0;
            r_sg        <= '0;
            r_gate_open <= 1'b0;
        end else begin
            if (in_take && !i_in.func && (mag > r_peak)) begin
                r_peak <= mag;
            end
            if (gate_close) begin
                r_gate_open <= 1'b0;
                r_peak      <= '0;
            end
            if (r_state == ST_SUM) begin
                r_sg        <= mix_sum[MIX_SHIFT +: GAIN_W];
                r_gate_open <= 1'b1;
                r_peak      <= '0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_sample <= i_in.sample_in;
            r_last   <= i_in.last;
        end
        if (r_state == ST_CLAMP) begin
            r_gain <= gain_clamped;
        end
        if (r_state == ST_MIX) begin
            r_acc <= prod[MIX_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_sample <= r_gate_open ? play_sat : '0;
            r_out_muted  <= !r_gate_open;
            r_out_last   <= r_last;
        end
    end

    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_sample;
    assign o_out.muted      = r_out_muted;
    assign o_out.last_out   = r_out_last;

    // A muted result is always silence
    a_muted_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.muted) |-> (o_out.sample_out == '0))
        else $error("muted result carries a non-zero sample");

    // After a microphone sample that does not end a buffer, the input is ready again in the next cycle
    a_mic_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !i_in.func && !i_in.last) |=> i_in.ready)
        else $error("non-final microphone sample held the input");

    // Peak magnitude never exceeds full scale
    a_peak_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak <= PEAK_MAX)
        else $error("peak level out of range");

    // A closing gate leaves the smoothed gain untouched
    a_gate_close_keeps_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gate_close |=> $stable(r_sg))
        else $error("smoothed gain changed while the gate closed");

endmodule

`default_nettype wire

FILE: hw/rtl/pgsg_mul.sv
`default_nettype none

// Shared signed multiplier with operand select and a registered product
module pgsg_mul #(
    parameter int SAMPLE_BITS = pgsg_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  pgsg_pkg::t_mul_op                     i_op,
    input  logic        [SAMPLE_BITS-1:0]         i_peak,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample,
    input  logic        [pgsg_pkg::GAIN_W-1:0]    i_max_gain,
    input  logic        [pgsg_pkg::GAIN_W-1:0]    i_gain,
    input  logic        [pgsg_pkg::GAIN_W-1:0]    i_smoothed,
    input  logic        [pgsg_pkg::WEIGHT_W-1:0]  i_keep_w,
    input  logic        [pgsg_pkg::WEIGHT_W-1:0]  i_new_w,
    output logic signed [pgsg_pkg::mul_a_w(SAMPLE_BITS)+pgsg_pkg::MUL_B_W-1:0] o_prod
);
    import pgsg_pkg::*;

    localparam int A_W = mul_a_w(SAMPLE_BITS);
    localparam int P_W = A_W + MUL_B_W;

    logic signed [A_W-1:0]     mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [P_W-1:0]     r_prod;

    // Operand select
    always_comb begin
        case (i_op)
            MUL_GAIN: begin
                mul_a = $signed({{(A_W-SAMPLE_BITS){1'b0}}, i_peak});
                mul_b = $signed({1'b0, i_max_gain});
            end
            MUL_KEEP: begin
                mul_a = $signed({{(A_W-WEIGHT_W){1'b0}}, i_keep_w});
                mul_b = $signed({1'b0, i_smoothed});
            end
            MUL_NEW: begin
                mul_a = $signed({{(A_W-WEIGHT_W){1'b0}}, i_new_w});
                mul_b = $signed({1'b0, i_gain});
            end
            MUL_PLAY: begin
                mul_a = $signed({{(A_W-SAMPLE_BITS){i_sample[SAMPLE_BITS-1]}}, i_sample});
                mul_b = $signed({1'b0, i_smoothed});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Product register
    always_ff @(posedge i_clk) begin
        r_prod <= P_W'(mul_a * mul_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire
